// ===== sv/pmbd_pkg.sv =====
// Shared constants, codes and word types for the PC memory bus decoder.
`timescale 1ns / 1ps

package pmbd_pkg;

  // Installed store size and derived bank geometry (four byte-wide banks)
  localparam int unsigned MEM_BYTES = 2097152;
  localparam int NUM_LANES  = 4;
  localparam int LANE_IDX_W = 2;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int ROW_W      = ADDR_W - LANE_IDX_W;
  localparam int BANK_ROWS  = MEM_BYTES / NUM_LANES;

  localparam logic [31:0] MEM_LIMIT   = 32'(MEM_BYTES);
  localparam logic [31:0] VGA_LO      = 32'h000A_0000;
  localparam logic [31:0] UMA_LO      = 32'h000C_0000;
  localparam logic [31:0] UMA_HI      = 32'h0010_0000;
  localparam logic [31:0] MASK_A20_ON = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_A20_OFF = ~32'h0010_0000;

  localparam int TOP_W = 22;
  localparam logic [TOP_W-1:0] RAM_TOP_RESET = 22'd2097152;

  // Configuration register indexes
  localparam logic CFG_A20     = 1'b0;
  localparam logic CFG_RAM_TOP = 1'b1;

  // Access codes
  localparam logic       ACTION_WRITE = 1'b1;
  localparam logic [1:0] SIZE_BYTE    = 2'd0;
  localparam logic [1:0] SIZE_HALF    = 2'd1;

  // Read byte source per lane
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_FF   = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic [NUM_LANES-1:0]                 bank_en;
    logic                                 bank_we;
    logic [NUM_LANES-1:0][ROW_W-1:0]      bank_row;
    logic [NUM_LANES-1:0][7:0]            bank_wdata;
    logic [NUM_LANES-1:0][1:0]            lane_src;
    logic [NUM_LANES-1:0][LANE_IDX_W-1:0] lane_bank;
    logic [NUM_LANES-1:0]                 vga_lanes;
    logic [31:0]                          base;
    logic [31:0]                          vga_wdata;
  } cmd_t;

  typedef struct packed {
    logic [31:0]          read_data;
    logic [NUM_LANES-1:0] vga_lanes;
    logic [31:0]          base;
    logic [31:0]          vga_wdata;
  } result_t;

endpackage

// ===== sv/pmbd_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module pmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/pmbd_front.sv =====
// Front end: masks the address, splits the access into byte lanes, classifies each lane.
`timescale 1ns / 1ps

module pmbd_front (
  input  logic                     action,
  input  logic [1:0]               size_code,
  input  logic [31:0]              address,
  input  logic [31:0]              write_data,
  input  logic                     a20_enable,
  input  logic [pmbd_pkg::TOP_W-1:0] ram_top,
  output pmbd_pkg::cmd_t           cmd
);
  import pmbd_pkg::*;

  logic [31:0]          mask;
  logic [31:0]          base;
  logic [31:0]          top_w;
  logic                 is_write;
  logic [31:0]          lane_addr [NUM_LANES];
  logic [NUM_LANES-1:0] active;
  logic [NUM_LANES-1:0] absent;
  logic [NUM_LANES-1:0] vga;
  logic [NUM_LANES-1:0] uma;

  assign mask     = a20_enable ? MASK_A20_ON : MASK_A20_OFF;
  assign base     = address & mask;
  assign top_w    = {{(32-TOP_W){1'b0}}, ram_top};
  assign is_write = (action == ACTION_WRITE);

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_addr[i] = (base + 32'(i)) & mask;
      unique case (size_code)
        SIZE_BYTE: active[i] = (i == 0);
        SIZE_HALF: active[i] = (i < 2);
        default:   active[i] = 1'b1;
      endcase
      absent[i] = (lane_addr[i] >= top_w) || (lane_addr[i] >= MEM_LIMIT);
      vga[i] = !absent[i] && (lane_addr[i] >= VGA_LO) && (lane_addr[i] < UMA_LO);
      uma[i] = !absent[i] && (lane_addr[i] >= UMA_LO) && (lane_addr[i] < UMA_HI);
    end
  end

  always_comb begin
    cmd = '0;
    cmd.bank_we = is_write;
    cmd.base    = base;
    for (int i = 0; i < NUM_LANES; i++) begin
      // low address bits of consecutive bytes differ, so each bank sees one lane at most
      cmd.lane_bank[i] = lane_addr[i][LANE_IDX_W-1:0];
      cmd.vga_lanes[i] = active[i] && vga[i];
      if (active[i] && vga[i] && is_write) begin
        cmd.vga_wdata[8*i +: 8] = write_data[8*i +: 8];
      end
      if (!active[i] || is_write || vga[i]) begin
        cmd.lane_src[i] = SRC_ZERO;
      end else if (absent[i] || uma[i]) begin
        cmd.lane_src[i] = SRC_FF;  // upper area is never written, always reads all ones
      end else begin
        cmd.lane_src[i] = SRC_RAM;
      end
      if (active[i] && !absent[i] && !vga[i] && !uma[i]) begin
        cmd.bank_en[lane_addr[i][LANE_IDX_W-1:0]]    = 1'b1;
        cmd.bank_row[lane_addr[i][LANE_IDX_W-1:0]]   = lane_addr[i][ADDR_W-1:LANE_IDX_W];
        cmd.bank_wdata[lane_addr[i][LANE_IDX_W-1:0]] = write_data[8*i +: 8];
      end
    end
  end

endmodule

// ===== sv/pmbd_cmdq.sv =====
// Short command queue between front end and back end.
`timescale 1ns / 1ps

module pmbd_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pmbd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output pmbd_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import pmbd_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entries [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== sv/pmbd_back.sv =====
// Back end: drives the byte banks, assembles the result word, holds the result queue.
`timescale 1ns / 1ps

module pmbd_back (
  input  logic              clk,
  input  logic              rst,
  input  pmbd_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output pmbd_pkg::result_t res,
  output logic              res_empty,
  input  logic              res_pop
);
  import pmbd_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  logic [NUM_LANES-1:0][7:0] bank_rdata;
  logic                      s1_valid;
  cmd_t                      s1_cmd;
  result_t                   s2_res;
  result_t                   entries [OUTQ_DEPTH];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [CNT_W-1:0]          count;
  logic                      do_pop;

  // issue only when the result queue has room for everything in flight
  assign cmd_pop = !cmd_empty && ((count + CNT_W'(s1_valid)) < CNT_W'(OUTQ_DEPTH));

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    pmbd_ram #(
      .WIDTH(8),
      .DEPTH(BANK_ROWS)
    ) u_bank (
      .clk  (clk),
      .en   (cmd_pop && cmd.bank_en[b]),
      .we   (cmd.bank_we),
      .addr (cmd.bank_row[b]),
      .wdata(cmd.bank_wdata[b]),
      .rdata(bank_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd <= cmd;
    end
  end

  always_comb begin
    s2_res.vga_lanes = s1_cmd.vga_lanes;
    s2_res.base      = s1_cmd.base;
    s2_res.vga_wdata = s1_cmd.vga_wdata;
    s2_res.read_data = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      case (s1_cmd.lane_src[i])
        SRC_FF:  s2_res.read_data[8*i +: 8] = 8'hFF;
        SRC_RAM: s2_res.read_data[8*i +: 8] = bank_rdata[s1_cmd.lane_bank[i]];
        default: s2_res.read_data[8*i +: 8] = 8'h00;
      endcase
    end
  end

  assign res_empty = (count == '0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (s1_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !s1_valid) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      entries[wr_ptr] <= s2_res;
    end
  end

endmodule

// ===== sv/pc_memory_bus_decoder_core.sv =====
// Top level of the PC memory bus decoder with A20 gate.
//
// Input side is a queue: an access word (action, size_code, address,
// write_data) is taken at a clock edge with push high and full low.
// Result side is a queue: while empty is low the oldest result sits on
// read_data, vga_lanes, vga_base_address and vga_write_data; it leaves at an
// edge with pop high. One result per access, in order.
// The front end classifies the byte lanes in the cycle the word is taken and
// parks a bank command in a two-entry queue. The back end drives four
// byte-wide RAM banks (one access per bank per cycle) and assembles the
// result from the registered bank read. A result passes the command queue,
// the bank read and the result queue; one access per cycle is sustained
// while pop stays high. A stalled receiver fills the four-entry result
// queue, then the command queue, then full rises. cfg_wr_en writes a20_enable
// (index 0) or ram_top (index 1) at once. Reset empties both queues, sets
// a20_enable to 1 and ram_top to 2 MiB; RAM content below 0xA0000 and above
// 0xFFFFF is undefined until written, the upper area always reads 0xFF.
`timescale 1ns / 1ps

module pc_memory_bus_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       action,
  input  logic [1:0]                 size_code,
  input  logic [31:0]                address,
  input  logic [31:0]                write_data,
  output logic                       empty,
  input  logic                       pop,
  output logic [31:0]                read_data,
  output logic [3:0]                 vga_lanes,
  output logic [31:0]                vga_base_address,
  output logic [31:0]                vga_write_data,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_addr,
  input  logic [pmbd_pkg::TOP_W-1:0] cfg_wdata
);
  import pmbd_pkg::*;

  logic             a20_enable;
  logic [TOP_W-1:0] ram_top;
  cmd_t             front_cmd;
  cmd_t             q_cmd;
  logic             q_empty;
  logic             q_pop;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      a20_enable <= 1'b1;
      ram_top    <= RAM_TOP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_A20:     a20_enable <= cfg_wdata[0];
        CFG_RAM_TOP: ram_top    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  pmbd_front u_front (
    .action    (action),
    .size_code (size_code),
    .address   (address),
    .write_data(write_data),
    .a20_enable(a20_enable),
    .ram_top   (ram_top),
    .cmd       (front_cmd)
  );

  pmbd_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(front_cmd),
    .full    (full),
    .pop     (q_pop),
    .pop_cmd (q_cmd),
    .empty   (q_empty)
  );

  pmbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_cmd),
    .cmd_empty(q_empty),
    .cmd_pop  (q_pop),
    .res      (res),
    .res_empty(empty),
    .res_pop  (pop)
  );

  assign read_data        = res.read_data;
  assign vga_lanes        = res.vga_lanes;
  assign vga_base_address = res.base;
  assign vga_write_data   = res.vga_wdata;

endmodule

// ===== sv/pmbd_checker.sv =====
// Port-level checker for the decoder top level, with its bind.
`timescale 1ns / 1ps

module pmbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] read_data,
  input logic [3:0]  vga_lanes,
  input logic [31:0] vga_base_address,
  input logic [31:0] vga_write_data
);

  logic [31:0] lane_mask;

  assign lane_mask = {{8{vga_lanes[3]}}, {8{vga_lanes[2]}},
                      {8{vga_lanes[1]}}, {8{vga_lanes[0]}}};

  // reset leaves both sides drained
  a_reset_drains: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // forwarded write bytes only on flagged lanes
  a_vga_data_lanes: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((vga_write_data & ~lane_mask) == 32'h0))
    else $error("vga write byte outside flagged lane");

  // flagged lanes read as zero
  a_vga_read_zero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((read_data & lane_mask) == 32'h0))
    else $error("vga lane returned read data");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(read_data) && $stable(vga_lanes)
      && $stable(vga_base_address) && $stable(vga_write_data))
    else $error("stalled result word changed");

endmodule

bind pc_memory_bus_decoder_core pmbd_checker u_pmbd_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .read_data       (read_data),
  .vga_lanes       (vga_lanes),
  .vga_base_address(vga_base_address),
  .vga_write_data  (vga_write_data)
);

// ===== tb/pc_memory_bus_decoder_core_test.sv =====
// Self-checking testbench for pc_memory_bus_decoder_core: random and directed accesses.
`timescale 1ns / 1ps

module pc_memory_bus_decoder_core_test;
  import pmbd_pkg::*;

  localparam logic       ACTION_READ = ~ACTION_WRITE;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_SPARE  = 2'd3;   // decodes as a word access
  localparam logic [31:0] A20_BIT    = ~MASK_A20_OFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {KIND_ABSENT, KIND_VGA, KIND_UPPER, KIND_RAM} byte_kind_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  size_code;
    logic [31:0] address;
    logic [31:0] write_data;
  } bus_access_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              push       = 1'b0;
  logic              full;
  logic              action     = ACTION_READ;
  logic [1:0]        size_code  = SIZE_BYTE;
  logic [31:0]       address    = '0;
  logic [31:0]       write_data = '0;
  logic              empty;
  logic              pop        = 1'b0;
  logic [31:0]       read_data;
  logic [3:0]        vga_lanes;
  logic [31:0]       vga_base_address;
  logic [31:0]       vga_write_data;
  logic              cfg_wr_en  = 1'b0;
  logic              cfg_addr   = CFG_A20;
  logic [TOP_W-1:0]  cfg_wdata  = '0;

  pc_memory_bus_decoder_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .size_code(size_code), .address(address), .write_data(write_data),
    .empty(empty), .pop(pop),
    .read_data(read_data), .vga_lanes(vga_lanes),
    .vga_base_address(vga_base_address), .vga_write_data(vga_write_data),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // decoder settings as the block currently holds them
  logic             cur_a20 = 1'b1;
  logic [TOP_W-1:0] cur_top = RAM_TOP_RESET;

  logic [7:0]  ram_image [logic [31:0]];     // store contents at acceptance time
  bit          ram_written [logic [31:0]];   // bytes written by queued words
  logic [31:0] written_bases [$];

  bus_access_t access_queue [$];
  result_t     predicted_results [$];
  int          issued_total   = 0;
  int          accepted_total = 0;
  int          received_total = 0;
  int          error_count    = 0;
  int          cycle_count    = 0;
  bit          steady         = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int lane_count(logic [1:0] sz);
    return (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
  endfunction

  function automatic logic [31:0] byte_address(logic [31:0] addr, int i);
    logic [31:0] mask;
    mask = cur_a20 ? MASK_A20_ON : MASK_A20_OFF;
    return ((addr & mask) + 32'(i)) & mask;
  endfunction

  // size limit is checked ahead of the VGA and upper-area windows
  function automatic byte_kind_t classify(logic [31:0] a);
    if (a >= 32'(cur_top) || a >= MEM_LIMIT) return KIND_ABSENT;
    if (a >= VGA_LO && a < UMA_LO) return KIND_VGA;
    if (a >= UMA_LO && a < UMA_HI) return KIND_UPPER;
    return KIND_RAM;
  endfunction

  function automatic bit read_defined(logic [1:0] sz, logic [31:0] addr);
    logic [31:0] a;
    for (int i = 0; i < lane_count(sz); i++) begin
      a = byte_address(addr, i);
      if (classify(a) == KIND_RAM && !ram_written.exists(a)) return 0;
    end
    return 1;
  endfunction

  function automatic result_t decode_access(bus_access_t w);
    result_t     r;
    logic [31:0] a;
    logic [7:0]  wb;
    logic [7:0]  rb;
    bit          is_write;
    r = '0;
    is_write = (w.action == ACTION_WRITE);
    r.base = w.address & (cur_a20 ? MASK_A20_ON : MASK_A20_OFF);
    for (int i = 0; i < lane_count(w.size_code); i++) begin
      a  = byte_address(w.address, i);
      wb = w.write_data[8*i +: 8];
      case (classify(a)) inside
        KIND_ABSENT, KIND_UPPER: begin
          rb = 8'hFF;
        end
        KIND_VGA: begin
          r.vga_lanes[i] = 1'b1;
          rb = 8'h00;
          if (is_write) r.vga_wdata[8*i +: 8] = wb;
        end
        default: begin
          if (is_write) ram_image[a] = wb;
          rb = ram_image.exists(a) ? ram_image[a] : 8'h00;
        end
      endcase
      if (!is_write) r.read_data[8*i +: 8] = rb;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] hot_spots [6];
    logic [31:0] addr;
    int r;
    hot_spots = '{VGA_LO, UMA_LO, UMA_HI, MEM_LIMIT, 32'(cur_top), 32'h0};
    r = $urandom_range(0, 99);
    if (r < 25) begin
      addr = 32'($urandom_range(0, 'h3FF));
    end else if (r < 45 && written_bases.size() > 0) begin
      addr = written_bases[$urandom_range(0, written_bases.size() - 1)]
             + 32'($urandom_range(0, 3));
    end else if (r < 70) begin
      addr = hot_spots[$urandom_range(0, 5)] - 32'd4 + 32'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) addr = addr ^ A20_BIT;
    end else if (r < 85) begin
      addr = 32'($urandom_range(0, 'h1FFFFF));
    end else begin
      addr = $urandom();
    end
    return addr;
  endfunction

  task automatic queue_access(logic act, logic [1:0] sz, logic [31:0] addr,
                              logic [31:0] data);
    logic [31:0] a;
    if (act == ACTION_READ && !read_defined(sz, addr)) return;
    if (act == ACTION_WRITE) begin
      for (int i = 0; i < lane_count(sz); i++) begin
        a = byte_address(addr, i);
        if (classify(a) == KIND_RAM) ram_written[a] = 1;
      end
      written_bases.push_back(addr);
      if (written_bases.size() > 256) void'(written_bases.pop_front());
    end
    access_queue.push_back('{act, sz, addr, data});
    issued_total++;
  endtask

  task automatic random_accesses(int count);
    logic        act;
    logic [1:0]  sz;
    logic [31:0] addr;
    int          tries;
    for (int k = 0; k < count; k++) begin
      act  = $urandom_range(0, 1) ? ACTION_WRITE : ACTION_READ;
      sz   = 2'($urandom_range(0, 3));
      addr = pick_address();
      tries = 0;
      while (act == ACTION_READ && !read_defined(sz, addr) && tries < 30) begin
        addr = pick_address();
        tries++;
      end
      // upper area always reads back as 0xFF
      if (act == ACTION_READ && !read_defined(sz, addr))
        addr = UMA_LO + 32'($urandom_range(0, 'h3FFF0));
      queue_access(act, sz, addr, $urandom());
    end
  endtask

  task automatic settle();
    while (accepted_total != issued_total || predicted_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(logic a20, logic [TOP_W-1:0] top);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_A20;
    cfg_wdata <= TOP_W'(a20);
    @(posedge clk);
    cfg_addr  <= CFG_RAM_TOP;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_a20 = a20;
    cur_top = top;
  endtask

  task automatic run_phase(logic a20, logic [TOP_W-1:0] top, int count);
    settle();
    write_config(a20, top);
    random_accesses(count / 2);
    settle();   // sender waits for every result before going on
    random_accesses(count - count / 2);
  endtask

  // driver: offers one word at a time, holds it while full is high
  bus_access_t offered;
  int          send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predicted_results.push_back(decode_access(offered));
        accepted_total++;
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (access_queue.size() > 0) begin
          offered     = access_queue.pop_front();
          push       <= 1'b1;
          action     <= offered.action;
          size_code  <= offered.size_code;
          address    <= offered.address;
          write_data <= offered.write_data;
          send_gap    = draw_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      error_count++;
    end
  endfunction

  // monitor: random pop gaps plus one long hold-off to back up the pipe
  int rx_gap = 0;
  int rx_hold_left = 0;
  bit long_hold_done = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        received_total++;
        if (predicted_results.size() == 0) begin
          $error("result word with nothing predicted");
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("vga_lanes", 32'(want.vga_lanes), 32'(vga_lanes));
          check_field("vga_base_address", want.base, vga_base_address);
          check_field("vga_write_data", want.vga_wdata, vga_write_data);
        end
        rx_gap = draw_gap();
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (!long_hold_done && received_total >= 150 && access_queue.size() > 30) begin
        long_hold_done = 1;
        rx_hold_left   = 250;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pc_memory_bus_decoder_core_test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: A20 on, full 2 MiB
    queue_access(ACTION_WRITE, SIZE_HALF,  32'h0000_0000, 32'h1234_5678);
    queue_access(ACTION_READ,  SIZE_BYTE,  32'h0000_0000, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h0000_0100, 32'hDEAD_BEEF);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h0000_0100, 32'h0);
    queue_access(ACTION_READ,  SIZE_HALF,  32'h0000_0102, 32'h0);
    queue_access(ACTION_WRITE, SIZE_SPARE, 32'h0000_0200, 32'hA5A5_5A5A);
    queue_access(ACTION_READ,  SIZE_SPARE, 32'h0000_0200, 32'h0);
    // RAM/VGA, VGA/upper-area and upper-area/RAM straddles
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h0009_FFFE, 32'hCAFE_F00D);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h0009_FFFE, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h000B_FFFE, 32'h0BAD_F00D);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h000B_FFFE, 32'h0);
    queue_access(ACTION_WRITE, SIZE_HALF,  32'h0010_0000, 32'h0000_5566);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h000F_FFFE, 32'h0);
    // end of store, and 32-bit wrap back to zero
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h001F_FFFE, 32'h89AB_CDEF);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h001F_FFFE, 32'h0);
    queue_access(ACTION_READ,  SIZE_WORD,  32'hFFFF_FFFE, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_access(ACTION_READ,  SIZE_BYTE,  32'hFFFF_FFFF, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h0000_0000, 32'h0000_0000);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h0000_0000, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  VGA_LO,        32'h1122_3344);
    queue_access(ACTION_READ,  SIZE_WORD,  VGA_LO,        32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  UMA_LO,        32'h55AA_55AA);
    queue_access(ACTION_READ,  SIZE_WORD,  UMA_LO,        32'h0);
    random_accesses(25);

    // A20 off: accesses crossing 1 MiB wrap to zero
    settle();
    write_config(1'b0, 22'h10_0000);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h000F_FFFE, 32'h0);
    queue_access(ACTION_WRITE, SIZE_WORD,  32'h001F_FFFE, 32'h7766_5544);
    queue_access(ACTION_READ,  SIZE_WORD,  32'h001F_FFFE, 32'h0);
    queue_access(ACTION_READ,  SIZE_HALF,  32'h0010_0100, 32'h0);
    random_accesses(100);

    steady = 1;
    run_phase(1'b1, 22'h3F_FFFF, 100);   // top beyond the store
    settle();
    steady = 0;
    run_phase(1'b0, 22'h0B_0000, 100);   // top inside the VGA window
    run_phase(1'b1, 22'h18_0000, 100);
    run_phase(1'b0, 22'h20_0000, 100);

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("pc_memory_bus_decoder_core_test passed");
    else
      $display("pc_memory_bus_decoder_core_test failed");
    $finish;
  end

endmodule
